### hdl/rmss_pkg.sv
// shared widths, operation codes and result kinds for the reverse activation
// max segment sum unit; no dependencies
`default_nettype none

package rmss_pkg;

  localparam int OP_W          = 2;
  localparam int POS_W         = 10;
  localparam int IN_VALUE_W    = 32;
  localparam int DEST_W        = 11;
  localparam int SUM_W         = 42;
  localparam int COUNT_W       = 11;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int VALUE_BITS_DEF   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_SPARE = 2'd3
  } op_t;

  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

endpackage

`default_nettype wire

### hdl/rmss_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module rmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hdl/reverse_activation_max_segment_sum_unit.sv
// top level: load, reverse merge run and answer read over ram based stores
// depends on rmss_pkg and rmss_ram
//
// channel | signals                                              | dir
// input   | in_valid in_ready operation position element_value   | in
//         | destroyed_position                                   |
// output  | out_valid out_ready result_kind answer_sum           | out
// config  | config_write config_data                             | in
//
// a load writes the value and order rams, a read passes through ST_RD; a run
// clears the segment ram, then per step reads its order entry and skips a bad
// entry or an already active position, else merges via self, left, right and
// two write states. sync reset clears control state only. a word is taken only
// in idle with the output register free or being drained in that cycle.
`default_nettype none

module reverse_activation_max_segment_sum_unit #(
  parameter int MAX_ELEMENTS = rmss_pkg::MAX_ELEMENTS_DEF,
  parameter int VALUE_BITS   = rmss_pkg::VALUE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [rmss_pkg::OP_W-1:0]       operation,
  input  wire logic [rmss_pkg::POS_W-1:0]      position,
  input  wire logic [rmss_pkg::IN_VALUE_W-1:0] element_value,
  input  wire logic [rmss_pkg::DEST_W-1:0]     destroyed_position,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 result_kind,
  output logic      [rmss_pkg::SUM_W-1:0]      answer_sum,
  input  wire logic                            config_write,
  input  wire logic [rmss_pkg::COUNT_W-1:0]    config_data
);

  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int CL_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int CNT_W  = (CL_W > rmss_pkg::COUNT_W) ? CL_W : rmss_pkg::COUNT_W;
  localparam int TOT_W  = (VALUE_BITS > rmss_pkg::SUM_W) ? VALUE_BITS : rmss_pkg::SUM_W;
  localparam logic [TOT_W:0] SUM_LIMIT =
    {{(TOT_W + 1 - rmss_pkg::SUM_W){1'b0}}, {rmss_pkg::SUM_W{1'b1}}};

  typedef struct packed {
    logic             active;
    logic [IDX_W-1:0] link;
    logic [TOT_W-1:0] total;
  } seg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_ORD,
    ST_CHK,
    ST_SELF,
    ST_LEFT,
    ST_RIGHT,
    ST_WS,
    ST_WE,
    ST_DONE,
    ST_RD
  } state_t;

  state_t                      state;
  logic [rmss_pkg::COUNT_W-1:0] count;
  logic [CNT_W-1:0]            k;
  logic [IDX_W-1:0]            p;
  logic [IDX_W-1:0]            seg_start;
  logic [IDX_W-1:0]            seg_end;
  logic [TOT_W-1:0]            sum;
  logic [TOT_W-1:0]            running_max;
  logic                        rd_ok;

  logic [CNT_W-1:0]            n_eff;
  logic                        accept;
  logic [IDX_W-1:0]            step;
  logic                        last_step;
  logic                        load_ok;
  logic                        ord_ok;
  logic [IDX_W-1:0]            p_ord;
  logic                        has_left;
  logic                        has_right;

  logic [VALUE_BITS-1:0]       value_rdata;
  logic [rmss_pkg::DEST_W-1:0] ord_rdata;
  logic [TOT_W-1:0]            ans_rdata;
  seg_t                        seg_rdata;
  logic                        seg_we;
  logic [IDX_W-1:0]            seg_waddr;
  seg_t                        seg_wdata;
  logic [IDX_W-1:0]            seg_raddr;
  logic                        ans_we;

  logic [TOT_W:0]              add_raw;
  logic [TOT_W-1:0]            add_sat;

  assign n_eff = (CNT_W'(count) > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                        : CNT_W'(count);
  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign step      = IDX_W'(k - CNT_W'(1));
  assign last_step = (k == CNT_W'(1));
  assign load_ok   = 32'(position) < 32'(MAX_ELEMENTS);
  assign ord_ok    = (ord_rdata != '0) && (CNT_W'(ord_rdata) <= n_eff);
  assign p_ord     = IDX_W'(CNT_W'(ord_rdata) - CNT_W'(1));
  assign has_left  = (p != '0);
  assign has_right = (CNT_W'(p) + CNT_W'(1)) < n_eff;

  // shared saturating adder
  assign add_raw = {1'b0, sum} + {1'b0, seg_rdata.total};
  assign add_sat = (add_raw > SUM_LIMIT) ? TOT_W'(SUM_LIMIT) : add_raw[TOT_W-1:0];

  always_comb begin
    seg_we    = 1'b0;
    seg_waddr = step;
    seg_wdata = '0;
    seg_raddr = p + IDX_W'(1);
    unique case (state)
      ST_CLR: begin
        seg_we = 1'b1;
      end
      ST_CHK: begin
        seg_raddr = p_ord;
      end
      ST_SELF: begin
        seg_raddr = p - IDX_W'(1);
      end
      ST_LEFT: begin
        seg_we    = 1'b1;
        seg_waddr = p;
        seg_wdata = '{active: 1'b1, link: p, total: '0};
      end
      ST_WS: begin
        seg_we    = 1'b1;
        seg_waddr = seg_start;
        seg_wdata = '{active: 1'b1, link: seg_end, total: sum};
      end
      ST_WE: begin
        seg_we    = 1'b1;
        seg_waddr = seg_end;
        seg_wdata = '{active: 1'b1, link: seg_start, total: sum};
      end
      default: begin
      end
    endcase
  end

  assign ans_we = (state == ST_ORD);

  rmss_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ELEMENTS)) u_value_ram (
    .clk     (clk),
    .wr_en   (accept && (operation == rmss_pkg::OP_LOAD) && load_ok),
    .wr_addr (IDX_W'(position)),
    .wr_data (VALUE_BITS'(element_value)),
    .rd_addr (p_ord),
    .rd_data (value_rdata)
  );

  rmss_ram #(.WIDTH(rmss_pkg::DEST_W), .DEPTH(MAX_ELEMENTS)) u_order_ram (
    .clk     (clk),
    .wr_en   (accept && (operation == rmss_pkg::OP_LOAD) && load_ok),
    .wr_addr (IDX_W'(position)),
    .wr_data (destroyed_position),
    .rd_addr (step),
    .rd_data (ord_rdata)
  );

  rmss_ram #(.WIDTH($bits(seg_t)), .DEPTH(MAX_ELEMENTS)) u_seg_ram (
    .clk     (clk),
    .wr_en   (seg_we),
    .wr_addr (seg_waddr),
    .wr_data (seg_wdata),
    .rd_addr (seg_raddr),
    .rd_data (seg_rdata)
  );

  rmss_ram #(.WIDTH(TOT_W), .DEPTH(MAX_ELEMENTS)) u_answer_ram (
    .clk     (clk),
    .wr_en   (ans_we),
    .wr_addr (step),
    .wr_data (running_max),
    .rd_addr (IDX_W'(position)),
    .rd_data (ans_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= rmss_pkg::COUNT_RESET;
      out_valid   <= 1'b0;
      running_max <= '0;
    end else begin
      if (config_write) begin
        count <= config_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (operation)
              rmss_pkg::OP_RUN: begin
                running_max <= '0;
                k           <= n_eff;
                state       <= (n_eff == '0) ? ST_DONE : ST_CLR;
              end
              rmss_pkg::OP_READ: begin
                rd_ok <= CNT_W'(position) < n_eff;
                state <= ST_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CLR: begin
          if (last_step) begin
            k     <= n_eff;
            state <= ST_ORD;
          end else begin
            k <= k - CNT_W'(1);
          end
        end
        ST_ORD: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          p <= p_ord;
          if (ord_ok) begin
            state <= ST_SELF;
          end else if (last_step) begin
            state <= ST_DONE;
          end else begin
            k     <= k - CNT_W'(1);
            state <= ST_ORD;
          end
        end
        ST_SELF: begin
          sum       <= TOT_W'(value_rdata);
          seg_start <= p;
          seg_end   <= p;
          if (!seg_rdata.active) begin
            state <= ST_LEFT;
          end else if (last_step) begin
            state <= ST_DONE;
          end else begin
            k     <= k - CNT_W'(1);
            state <= ST_ORD;
          end
        end
        ST_LEFT: begin
          if (has_left && seg_rdata.active) begin
            seg_start <= seg_rdata.link;
            sum       <= add_sat;
          end
          state <= ST_RIGHT;
        end
        ST_RIGHT: begin
          if (has_right && seg_rdata.active) begin
            seg_end <= seg_rdata.link;
            sum     <= add_sat;
          end
          state <= ST_WS;
        end
        ST_WS: begin
          if (sum > running_max) begin
            running_max <= sum;
          end
          state <= ST_WE;
        end
        ST_WE: begin
          if (last_step) begin
            state <= ST_DONE;
          end else begin
            k     <= k - CNT_W'(1);
            state <= ST_ORD;
          end
        end
        ST_DONE: begin
          out_valid   <= 1'b1;
          result_kind <= rmss_pkg::KIND_RUN;
          answer_sum  <= running_max[rmss_pkg::SUM_W-1:0];
          state       <= ST_IDLE;
        end
        ST_RD: begin
          out_valid   <= 1'b1;
          result_kind <= rmss_pkg::KIND_READ;
          answer_sum  <= rd_ok ? ans_rdata[rmss_pkg::SUM_W-1:0] : '0;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
